@@ rtl/qte_pkg.sv @@
`timescale 1ns / 1ps
package qte_pkg;

	// default configuration
	localparam int COMPONENT_BITS = 16;
	localparam int CORDIC_STAGES  = 16;

	// asin path: sine and cosine in Q30, integer square root one bit per cell
	localparam int Q_FRAC   = 30;
	localparam int S30_W    = 32;
	localparam int SQ_W     = 62;
	localparam int SQ_STEPS = 31;

	// angles in 1/65536 degree
	localparam int ANG_W     = 26;
	localparam int HALF_TURN = 180 * 65536;
	localparam int ROUND_BIAS = 256;
	localparam int OUT_SHIFT  = 9;

	// output ranges in 1/128 degree
	localparam int ROLL_LIMIT  = 23040;
	localparam int PITCH_LIMIT = 11520;
	localparam int ROLL_W      = 16;
	localparam int PITCH_W     = 15;

	// round(atan(2^-i) in 1/65536 degree)
	function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
		logic signed [ANG_W-1:0] a;
		case (idx)
			0: a = ANG_W'(2949120);
			1: a = ANG_W'(1740967);
			2: a = ANG_W'(919879);
			3: a = ANG_W'(466945);
			4: a = ANG_W'(234379);
			5: a = ANG_W'(117303);
			6: a = ANG_W'(58666);
			7: a = ANG_W'(29335);
			8: a = ANG_W'(14668);
			9: a = ANG_W'(7334);
			10: a = ANG_W'(3667);
			11: a = ANG_W'(1833);
			12: a = ANG_W'(917);
			13: a = ANG_W'(458);
			14: a = ANG_W'(229);
			15: a = ANG_W'(115);
			16: a = ANG_W'(57);
			17: a = ANG_W'(29);
			18: a = ANG_W'(14);
			19: a = ANG_W'(7);
			20: a = ANG_W'(4);
			21: a = ANG_W'(2);
			22: a = ANG_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

@@ rtl/qte_if.sv @@
`timescale 1ns / 1ps
// quaternion input channel
interface qte_in_if #(parameter int CB = qte_pkg::COMPONENT_BITS);
	logic valid;
	logic ready;
	logic signed [CB-1:0] quat_w;
	logic signed [CB-1:0] quat_x;
	logic signed [CB-1:0] quat_y;
	logic signed [CB-1:0] quat_z;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// euler angle output channel
interface qte_out_if;
	logic valid;
	logic ready;
	logic signed [qte_pkg::ROLL_W-1:0] roll_angle;
	logic signed [qte_pkg::PITCH_W-1:0] pitch_angle;
	logic signed [qte_pkg::ROLL_W-1:0] yaw_angle;
	logic pitch_saturated;
	modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
		input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
		output ready);
endinterface

@@ rtl/qte_front.sv @@
`timescale 1ns / 1ps
module qte_front #(
	parameter int CB = 16,
	parameter int PW = 32,
	parameter int WW = 35,
	parameter int WF = 28,
	parameter int PROD_SHIFT = 0
) (
	input  logic clk,
	input  logic [3:0] en,
	input  logic signed [CB-1:0] w,
	input  logic signed [CB-1:0] x,
	input  logic signed [CB-1:0] y,
	input  logic signed [CB-1:0] z,
	output logic signed [WW-1:0] rnum,
	output logic signed [WW-1:0] rden,
	output logic signed [WW-1:0] ynum,
	output logic signed [WW-1:0] yden,
	output logic signed [qte_pkg::S30_W-1:0] s30,
	output logic sat,
	output logic [qte_pkg::SQ_W-1:0] num
);
	localparam int SH_R = (WF >= qte_pkg::Q_FRAC) ? WF - qte_pkg::Q_FRAC : 0;
	localparam int SH_L = (WF < qte_pkg::Q_FRAC) ? qte_pkg::Q_FRAC - WF : 0;
	localparam logic signed [WW-1:0] ONE = WW'(1) <<< WF;
	localparam int MAG_W = qte_pkg::S30_W - 1;

	function automatic logic signed [PW-1:0] prod(input logic signed [CB-1:0] a,
		input logic signed [CB-1:0] b);
		logic signed [2*CB-1:0] f;
		f = a * b;
		return PW'(f >>> PROD_SHIFT);
	endfunction

	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, xz_s1;
	logic signed [WW-1:0] rnum_s2, rden_s2, ynum_s2, yden_s2;
	logic signed [WW-1:0] rnum_s3, rden_s3, ynum_s3, yden_s3;
	logic signed [WW-1:0] rnum_s4, rden_s4, ynum_s4, yden_s4;
	logic signed [qte_pkg::S30_W-1:0] s30_s2, s30_s3, s30_s4;
	logic sat_s2, sat_s3, sat_s4;
	logic [qte_pkg::SQ_W-1:0] sqq_s3, num_s4;

	logic signed [WW-1:0] sarg, sclip;
	logic signed [63:0] swide;
	logic sclip_hit;
	logic [MAG_W-1:0] smag;

	// component products for the angle terms
	always_ff @(posedge clk) begin
		if (en[0]) begin
			wx_s1 <= prod(w, x);
			yz_s1 <= prod(y, z);
			xx_s1 <= prod(x, x);
			yy_s1 <= prod(y, y);
			wz_s1 <= prod(w, z);
			xy_s1 <= prod(x, y);
			zz_s1 <= prod(z, z);
			wy_s1 <= prod(w, y);
			xz_s1 <= prod(x, z);
		end
	end

	// asin argument, clipped to one and brought to Q30
	always_comb begin
		sarg = (WW'(wy_s1) - WW'(xz_s1)) <<< 1;
		sclip = sarg;
		sclip_hit = 1'b0;
		if (sarg > ONE) begin
			sclip = ONE;
			sclip_hit = 1'b1;
		end else if (sarg < -ONE) begin
			sclip = -ONE;
			sclip_hit = 1'b1;
		end
		swide = 64'(sclip);
	end

	// numerators and denominators
	always_ff @(posedge clk) begin
		if (en[1]) begin
			rnum_s2 <= (WW'(wx_s1) + WW'(yz_s1)) <<< 1;
			rden_s2 <= ONE - ((WW'(xx_s1) + WW'(yy_s1)) <<< 1);
			ynum_s2 <= (WW'(wz_s1) + WW'(xy_s1)) <<< 1;
			yden_s2 <= ONE - ((WW'(yy_s1) + WW'(zz_s1)) <<< 1);
			s30_s2 <= qte_pkg::S30_W'((swide >>> SH_R) <<< SH_L);
			sat_s2 <= sclip_hit;
		end
	end

	// sine squared
	assign smag = s30_s2[qte_pkg::S30_W-1] ? MAG_W'(-s30_s2) : MAG_W'(s30_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sqq_s3 <= smag * smag;
			rnum_s3 <= rnum_s2;
			rden_s3 <= rden_s2;
			ynum_s3 <= ynum_s2;
			yden_s3 <= yden_s2;
			s30_s3 <= s30_s2;
			sat_s3 <= sat_s2;
		end
	end

	// one minus sine squared, radicand for the cosine
	always_ff @(posedge clk) begin
		if (en[3]) begin
			num_s4 <= (qte_pkg::SQ_W'(1) << (2 * qte_pkg::Q_FRAC)) - sqq_s3;
			rnum_s4 <= rnum_s3;
			rden_s4 <= rden_s3;
			ynum_s4 <= ynum_s3;
			yden_s4 <= yden_s3;
			s30_s4 <= s30_s3;
			sat_s4 <= sat_s3;
		end
	end

	assign rnum = rnum_s4;
	assign rden = rden_s4;
	assign ynum = ynum_s4;
	assign yden = yden_s4;
	assign s30 = s30_s4;
	assign sat = sat_s4;
	assign num = num_s4;

endmodule

@@ rtl/qte_sqrt_cell.sv @@
`timescale 1ns / 1ps
module qte_sqrt_cell #(
	parameter int STEP = 0,
	parameter int PASS_W = 8
) (
	input  logic clk,
	input  logic en,
	input  logic [qte_pkg::SQ_W-1:0] num_i,
	input  logic [qte_pkg::SQ_W-1:0] res_i,
	input  logic [PASS_W-1:0] pass_i,
	output logic [qte_pkg::SQ_W-1:0] num_o,
	output logic [qte_pkg::SQ_W-1:0] res_o,
	output logic [PASS_W-1:0] pass_o
);
	localparam logic [qte_pkg::SQ_W-1:0] BIT =
		qte_pkg::SQ_W'(1) << (2 * qte_pkg::Q_FRAC - 2 * STEP);

	logic [qte_pkg::SQ_W-1:0] trial;
	logic [qte_pkg::SQ_W-1:0] num_s1, res_s1;
	logic [PASS_W-1:0] pass_s1;

	assign trial = res_i + BIT;

	// one restoring root bit
	always_ff @(posedge clk) begin
		if (en) begin
			if (num_i >= trial) begin
				num_s1 <= num_i - trial;
				res_s1 <= (res_i >> 1) + BIT;
			end else begin
				num_s1 <= num_i;
				res_s1 <= res_i >> 1;
			end
			pass_s1 <= pass_i;
		end
	end

	assign num_o = num_s1;
	assign res_o = res_s1;
	assign pass_o = pass_s1;

endmodule

@@ rtl/qte_cordic_cell.sv @@
`timescale 1ns / 1ps
module qte_cordic_cell #(
	parameter int STEP = 0,
	parameter int CW = 37
) (
	input  logic clk,
	input  logic en,
	input  logic signed [CW-1:0] x_i,
	input  logic signed [CW-1:0] y_i,
	input  logic signed [qte_pkg::ANG_W-1:0] z_i,
	output logic signed [CW-1:0] x_o,
	output logic signed [CW-1:0] y_o,
	output logic signed [qte_pkg::ANG_W-1:0] z_o
);
	localparam logic signed [qte_pkg::ANG_W-1:0] ATAN = qte_pkg::atan_entry(STEP);

	logic signed [CW-1:0] dx, dy;
	logic signed [CW-1:0] x_s1, y_s1;
	logic signed [qte_pkg::ANG_W-1:0] z_s1;

	assign dx = y_i >>> STEP;
	assign dy = x_i >>> STEP;

	// vectoring micro-rotation toward the x axis
	always_ff @(posedge clk) begin
		if (en) begin
			if (y_i > 0) begin
				x_s1 <= x_i + dx;
				y_s1 <= y_i - dy;
				z_s1 <= z_i + ATAN;
			end else begin
				x_s1 <= x_i - dx;
				y_s1 <= y_i + dy;
				z_s1 <= z_i - ATAN;
			end
		end
	end

	assign x_o = x_s1;
	assign y_o = y_s1;
	assign z_o = z_s1;

endmodule

@@ rtl/quaternion_to_euler_zyx.sv @@
`timescale 1ns / 1ps
// stages from accepted quaternion to result: front stages, 31 square-root cells,
// the pre-rotation stage, the CORDIC_STAGES rotation cells and the output register
// one item per cycle unless euler.ready is low; a stage holds one item until the next is free
// reset clears the stage valid bits only; datapath registers are not reset
module quaternion_to_euler_zyx #(
	parameter int COMPONENT_BITS = qte_pkg::COMPONENT_BITS,
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES
) (
	input  logic clk,
	input  logic arst_n,
	qte_in_if.sink quat,
	qte_out_if.source euler
);
	localparam int CB = COMPONENT_BITS;
	localparam int FRAC_IN = CB - 2;
	localparam int PROD_SHIFT = (2 * CB > 58) ? 2 * CB - 58 : 0;
	localparam int WF = 2 * FRAC_IN - PROD_SHIFT;
	localparam int PW = 2 * CB - PROD_SHIFT;
	localparam int WW = PW + 3;
	localparam int CW = ((WW > qte_pkg::S30_W) ? WW : qte_pkg::S30_W) + 2;
	localparam int SQN = qte_pkg::SQ_STEPS;
	localparam int S30W = qte_pkg::S30_W;
	localparam int AW = qte_pkg::ANG_W;
	localparam int PASS_W = 4 * WW + S30W + 1;
	localparam int PRE = 4 + SQN;
	localparam int NST = 6 + SQN + CORDIC_STAGES;

	// stage valid bits and advance chain
	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !v_q[NST-1] || euler.ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= quat.valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign quat.ready = en[0];
	assign euler.valid = v_q[NST-1];

	// products, sums and radicand
	logic signed [WW-1:0] f_rnum, f_rden, f_ynum, f_yden;
	logic signed [S30W-1:0] f_s30;
	logic f_sat;
	logic [qte_pkg::SQ_W-1:0] f_num;

	qte_front #(
		.CB(CB), .PW(PW), .WW(WW), .WF(WF), .PROD_SHIFT(PROD_SHIFT)
	) u_front (
		.clk(clk),
		.en(en[3:0]),
		.w(quat.quat_w),
		.x(quat.quat_x),
		.y(quat.quat_y),
		.z(quat.quat_z),
		.rnum(f_rnum),
		.rden(f_rden),
		.ynum(f_ynum),
		.yden(f_yden),
		.s30(f_s30),
		.sat(f_sat),
		.num(f_num)
	);

	// square root chain, other operands ride along
	logic [qte_pkg::SQ_W-1:0] sq_num [SQN+1];
	logic [qte_pkg::SQ_W-1:0] sq_res [SQN+1];
	logic [PASS_W-1:0] sq_pass [SQN+1];

	assign sq_num[0] = f_num;
	assign sq_res[0] = '0;
	assign sq_pass[0] = {f_rnum, f_rden, f_ynum, f_yden, f_s30, f_sat};

	for (genvar k = 0; k < SQN; k++) begin : g_sqrt
		qte_sqrt_cell #(.STEP(k), .PASS_W(PASS_W)) u_cell (
			.clk(clk),
			.en(en[4+k]),
			.num_i(sq_num[k]),
			.res_i(sq_res[k]),
			.pass_i(sq_pass[k]),
			.num_o(sq_num[k+1]),
			.res_o(sq_res[k+1]),
			.pass_o(sq_pass[k+1])
		);
	end

	logic signed [WW-1:0] t_rnum, t_rden, t_ynum, t_yden;
	logic signed [S30W-1:0] t_s30;
	logic t_sat;
	logic signed [CW-1:0] vx [3];
	logic signed [CW-1:0] vy [3];

	assign {t_rnum, t_rden, t_ynum, t_yden, t_s30, t_sat} = sq_pass[SQN];

	// vectors for roll, pitch and yaw
	always_comb begin
		vx[0] = CW'(t_rden);
		vy[0] = CW'(t_rnum);
		vx[1] = CW'({1'b0, sq_res[SQN][S30W-2:0]});
		vy[1] = CW'(t_s30);
		vx[2] = CW'(t_yden);
		vy[2] = CW'(t_ynum);
	end

	// cordic chain, index 0 is the pre-rotation stage
	logic signed [CW-1:0] cx [CORDIC_STAGES+1][3];
	logic signed [CW-1:0] cy [CORDIC_STAGES+1][3];
	logic signed [AW-1:0] cz [CORDIC_STAGES+1][3];
	logic signed [CW-1:0] rot_x_s1 [3];
	logic signed [CW-1:0] rot_y_s1 [3];
	logic signed [AW-1:0] rot_z_s1 [3];
	logic [3:0] fl_s [CORDIC_STAGES+1];

	// half-turn pre-rotation for vectors in the left half plane, flags ride along
	always_ff @(posedge clk) begin
		if (en[PRE]) begin
			for (int j = 0; j < 3; j++) begin
				if (vx[j] < 0) begin
					rot_x_s1[j] <= -vx[j];
					rot_y_s1[j] <= -vy[j];
					rot_z_s1[j] <= (vy[j] >= 0) ? AW'(qte_pkg::HALF_TURN) :
						-AW'(qte_pkg::HALF_TURN);
				end else begin
					rot_x_s1[j] <= vx[j];
					rot_y_s1[j] <= vy[j];
					rot_z_s1[j] <= '0;
				end
			end
			fl_s[0] <= {t_sat, vx[2] == 0 && vy[2] == 0, vx[1] == 0 && vy[1] == 0,
				vx[0] == 0 && vy[0] == 0};
		end
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (en[PRE+1+i]) fl_s[i+1] <= fl_s[i];
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_rot
		assign cx[0][j] = rot_x_s1[j];
		assign cy[0][j] = rot_y_s1[j];
		assign cz[0][j] = rot_z_s1[j];
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		for (genvar j = 0; j < 3; j++) begin : g_vec
			qte_cordic_cell #(.STEP(i), .CW(CW)) u_cell (
				.clk(clk),
				.en(en[PRE+1+i]),
				.x_i(cx[i][j]),
				.y_i(cy[i][j]),
				.z_i(cz[i][j]),
				.x_o(cx[i+1][j]),
				.y_o(cy[i+1][j]),
				.z_o(cz[i+1][j])
			);
		end
	end

	// round to 1/128 degree and clamp; a zero input vector gives angle zero
	logic signed [AW-1:0] rnd [3];
	logic signed [AW-1:0] lim [3];
	logic signed [AW-1:0] ang [3];

	always_comb begin
		lim[0] = AW'(qte_pkg::ROLL_LIMIT);
		lim[1] = AW'(qte_pkg::PITCH_LIMIT);
		lim[2] = AW'(qte_pkg::ROLL_LIMIT);
		for (int j = 0; j < 3; j++) begin
			rnd[j] = (cz[CORDIC_STAGES][j] + AW'(qte_pkg::ROUND_BIAS)) >>> qte_pkg::OUT_SHIFT;
			if (fl_s[CORDIC_STAGES][j]) ang[j] = '0;
			else if (rnd[j] > lim[j]) ang[j] = lim[j];
			else if (rnd[j] < -lim[j]) ang[j] = -lim[j];
			else ang[j] = rnd[j];
		end
	end

	logic signed [qte_pkg::ROLL_W-1:0] roll_q, yaw_q;
	logic signed [qte_pkg::PITCH_W-1:0] pitch_q;
	logic sat_q;

	// output register
	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			roll_q <= ang[0][qte_pkg::ROLL_W-1:0];
			pitch_q <= ang[1][qte_pkg::PITCH_W-1:0];
			yaw_q <= ang[2][qte_pkg::ROLL_W-1:0];
			sat_q <= fl_s[CORDIC_STAGES][3];
		end
	end

	assign euler.roll_angle = roll_q;
	assign euler.pitch_angle = pitch_q;
	assign euler.yaw_angle = yaw_q;
	assign euler.pitch_saturated = sat_q;

endmodule

@@ tb/quaternion_to_euler_zyx_test.sv @@
`timescale 1ns / 1ps
module quaternion_to_euler_zyx_test;

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [qte_pkg::ROLL_W-1:0] roll;
		logic signed [qte_pkg::PITCH_W-1:0] pitch;
		logic signed [qte_pkg::ROLL_W-1:0] yaw;
		logic sat;
	} euler_t;

	localparam int RANDOM_ITEMS = 1050;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;
	localparam int LONG_HOLD = 400;

	// arctangent steps in 1/65536 degree
	localparam longint ARCTAN_STEP [16] = '{2949120, 1740967, 919879, 466945, 234379,
		117303, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qte_in_if quat_ch ();
	qte_out_if euler_ch ();

	quaternion_to_euler_zyx dut (
		.clk(clk),
		.arst_n(arst_n),
		.quat(quat_ch.sink),
		.euler(euler_ch.source)
	);

	quat_t pending_quats[$];
	euler_t expected_angles[$];
	int errors = 0;
	int quats_taken = 0;
	bit calm = 1'b0;

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// square root by restoring digit pairs
	function automatic longint unsigned int_sqrt(input longint unsigned num);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > num)
			b = b >> 2;
		while (b != 0) begin
			if (num >= res + b) begin
				num = num - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// vectoring rotation, angle in 1/65536 degree
	function automatic longint vector_angle(input longint ys, input longint xs);
		longint px, py, ang, dx, dy;
		px = xs;
		py = ys;
		ang = 0;
		if (px == 0 && py == 0)
			return 0;
		if (px < 0) begin
			ang = (py >= 0) ? qte_pkg::HALF_TURN : -qte_pkg::HALF_TURN;
			px = -px;
			py = -py;
		end
		for (int i = 0; i < 16; i++) begin
			dx = py >>> i;
			dy = px >>> i;
			if (py > 0) begin
				px += dx;
				py -= dy;
				ang += ARCTAN_STEP[i];
			end else begin
				px -= dx;
				py += dy;
				ang -= ARCTAN_STEP[i];
			end
		end
		return ang;
	endfunction

	// round half up to 1/128 degree and clamp
	function automatic longint to_step128(input longint ang, input longint lim);
		longint r;
		r = (ang + qte_pkg::ROUND_BIAS) >>> qte_pkg::OUT_SHIFT;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic euler_t zyx_angles(input quat_t q);
		longint w, x, y, z, one, rnum, rden, ynum, yden, sarg, s30;
		longint unsigned mag;
		euler_t e;
		w = q.w;
		x = q.x;
		y = q.y;
		z = q.z;
		one = 64'sd1 << 28;
		rnum = 2 * (w * x + y * z);
		rden = one - 2 * (x * x + y * y);
		ynum = 2 * (w * z + x * y);
		yden = one - 2 * (y * y + z * z);
		sarg = 2 * (w * y - x * z);
		e.sat = 1'b0;
		if (sarg > one) begin
			sarg = one;
			e.sat = 1'b1;
		end
		if (sarg < -one) begin
			sarg = -one;
			e.sat = 1'b1;
		end
		s30 = sarg * 4;
		mag = (s30 < 0) ? -s30 : s30;
		e.roll = qte_pkg::ROLL_W'(to_step128(vector_angle(rnum, rden), qte_pkg::ROLL_LIMIT));
		e.pitch = qte_pkg::PITCH_W'(to_step128(vector_angle(s30,
			longint'(int_sqrt((64'd1 << 60) - mag * mag))), qte_pkg::PITCH_LIMIT));
		e.yaw = qte_pkg::ROLL_W'(to_step128(vector_angle(ynum, yden), qte_pkg::ROLL_LIMIT));
		return e;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// predict on every accepted input item
	always @(posedge clk) begin
		if (arst_n && quat_ch.valid && quat_ch.ready) begin
			expected_angles.push_back(zyx_angles({quat_ch.quat_w, quat_ch.quat_x,
				quat_ch.quat_y, quat_ch.quat_z}));
			quats_taken++;
		end
	end

	// driver with random idle bursts
	int send_gap = 0;
	bit in_taken = 1'b0;
	initial begin
		quat_ch.valid = 1'b0;
		quat_ch.quat_w = '0;
		quat_ch.quat_x = '0;
		quat_ch.quat_y = '0;
		quat_ch.quat_z = '0;
	end
	always @(posedge clk)
		in_taken <= quat_ch.valid && quat_ch.ready;
	always @(negedge clk) begin
		quat_t q;
		logic v;
		if (arst_n && (!quat_ch.valid || in_taken)) begin
			v = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(1, 15) - 1;
			end else if (pending_quats.size() > 0) begin
				q = pending_quats.pop_front();
				v = 1'b1;
				quat_ch.quat_w <= q.w;
				quat_ch.quat_x <= q.x;
				quat_ch.quat_y <= q.y;
				quat_ch.quat_z <= q.z;
			end
			quat_ch.valid <= v;
		end
	end

	// receiver: random stall bursts plus one long hold-off
	int stall_left = 0;
	bit held_once = 1'b0;
	initial euler_ch.ready = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held_once && quats_taken >= 300) begin
				held_once = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				euler_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				euler_ch.ready <= 1'b0;
			end else begin
				euler_ch.ready <= 1'b1;
			end
		end
	end

	// monitor: compare each result item with the oldest prediction
	always @(posedge clk) begin
		euler_t want;
		if (arst_n && euler_ch.valid && euler_ch.ready) begin
			if (expected_angles.size() == 0) begin
				report("unexpected result item, roll", euler_ch.roll_angle, 0);
			end else begin
				want = expected_angles.pop_front();
				if (euler_ch.roll_angle !== want.roll)
					report("roll", euler_ch.roll_angle, want.roll);
				if (euler_ch.pitch_angle !== want.pitch)
					report("pitch", euler_ch.pitch_angle, want.pitch);
				if (euler_ch.yaw_angle !== want.yaw)
					report("yaw", euler_ch.yaw_angle, want.yaw);
				if (euler_ch.pitch_saturated !== want.sat)
					report("saturation", euler_ch.pitch_saturated, want.sat);
			end
		end
	end

	// watchdog on cycles with no handshake
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((quat_ch.valid && quat_ch.ready) || (euler_ch.valid && euler_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("quaternion_to_euler_zyx_test failed");
			$finish;
		end
	end

	function automatic quat_t make_quat(input int w, input int x, input int y, input int z);
		quat_t q;
		q.w = w[15:0];
		q.x = x[15:0];
		q.y = y[15:0];
		q.z = z[15:0];
		return q;
	endfunction

	initial begin
		quat_t q;
		// directed: identity, zero, extremes, saturation, negative denominators
		pending_quats.push_back(make_quat(0, 0, 0, 0));
		pending_quats.push_back(make_quat(16384, 0, 0, 0));
		pending_quats.push_back(make_quat(-16384, 0, 0, 0));
		pending_quats.push_back(make_quat(0, 16384, 0, 0));
		pending_quats.push_back(make_quat(0, 0, 16384, 0));
		pending_quats.push_back(make_quat(0, 0, 0, 16384));
		pending_quats.push_back(make_quat(11585, 11585, 0, 0));
		pending_quats.push_back(make_quat(11585, 0, 11585, 0));
		pending_quats.push_back(make_quat(11585, 0, -11585, 0));
		pending_quats.push_back(make_quat(11585, 0, 0, -11585));
		pending_quats.push_back(make_quat(0, 11585, 11585, 0));
		pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
		pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
		pending_quats.push_back(make_quat(32767, -32768, 32767, -32768));
		pending_quats.push_back(make_quat(-32768, 32767, 32767, -32768));
		pending_quats.push_back(make_quat(16384, 0, 16384, 0));
		pending_quats.push_back(make_quat(0, 16384, 0, -16384));
		pending_quats.push_back(make_quat(0, 0, 11585, 11585));
		pending_quats.push_back(make_quat(8192, 8192, 8192, 8192));
		pending_quats.push_back(make_quat(-8192, 8192, -8192, 8192));
		pending_quats.push_back(make_quat(1, -1, 1, -1));
		// random: mostly components within +-11585, some full-range noise
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 2) == 0)
				q = quat_t'({$urandom(), $urandom()});
			else
				q = make_quat($urandom_range(0, 23170) - 11585, $urandom_range(0, 23170) - 11585,
					$urandom_range(0, 23170) - 11585, $urandom_range(0, 23170) - 11585);
			pending_quats.push_back(q);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_quats.size() < 150);
		calm = 1'b1;
		wait (pending_quats.size() == 0 && !quat_ch.valid);
		wait (expected_angles.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("quaternion_to_euler_zyx_test passed");
		else
			$display("quaternion_to_euler_zyx_test failed");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/qte_pkg.sv
rtl/qte_if.sv
rtl/qte_front.sv
rtl/qte_sqrt_cell.sv
rtl/qte_cordic_cell.sv
rtl/quaternion_to_euler_zyx.sv
tb/quaternion_to_euler_zyx_test.sv
